/* rtl/assert_macros.svh */
// assertion macros shared by the charge pipeline files
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// clocked check, switched off while reset is high
`define CHG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// clocked check that also holds across reset
`define CHG_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHG_ASSERT(label, clk, rst, prop, msg)
`define CHG_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

/* rtl/chg_pkg.sv */
// types, constants and elaboration-time tables of the charge pipeline
// no dependencies; imported by every module of the block
package chg_pkg;

  localparam int OUT_FRAC_BITS_DEF = 10;
  localparam int DIV_STEPS  = 54;
  localparam int SQRT_STEPS = 27;
  localparam int LOG_STEPS  = 24;
  localparam int EXP_STEPS  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] TOF_OFFSET_RST = 16'd19883;
  localparam logic [15:0] LIGHT_TIME_RST = 16'd3011;
  localparam logic [15:0] REF_TIME_RST   = 16'd4325;
  localparam logic [12:0] DE_OFFSET_RST  = 13'd80;
  localparam logic [14:0] DE_DIVISOR_RST = 15'd5120;
  localparam logic [14:0] Z_OFFSET_RST   = 15'd0;
  localparam logic [14:0] Z_SLOPE_RST    = 15'd16384;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LIGHT  = 2'd1,
    ST_ENERGY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOF_OFFSET = 3'd0,
    CFG_LIGHT_TIME = 3'd1,
    CFG_REF_TIME   = 3'd2,
    CFG_DE_OFFSET  = 3'd3,
    CFG_DE_DIVISOR = 3'd4,
    CFG_Z_OFFSET   = 3'd5,
    CFG_Z_SLOPE    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] tof_time;
    logic [15:0] energy_loss;
  } hit_t;

  typedef struct packed {
    logic [15:0] charge_value;
    status_t     status;
  } result_t;

  // everything one event carries down the row of cells
  typedef struct packed {
    status_t     status;
    logic [16:0] t;       // flight time
    logic [53:0] dq;      // dividend in, quotient out, then sqrt operand
    logic [14:0] rem_d;   // division remainder
    logic [28:0] rem_s;   // sqrt remainder
    logic [26:0] root;    // sqrt result
    logic [31:0] mt;      // log mantissa of flight time
    logic [31:0] mr;      // log mantissa of reference time
    logic [4:0]  nt;
    logic [4:0]  nr;
    logic [23:0] ft;      // log fraction bits
    logic [23:0] fr;
    logic        neg;
    logic [32:0] x13;
    logic [29:0] qe;
    logic [6:0]  ip;      // integer part of exponent, signed
    logic [23:0] frac;
    logic [30:0] acc;     // exp2 fraction product, Q30
    logic [37:0] p;       // velocity factor, Q16
    logic [45:0] pp_lo;
    logic [45:0] pp_hi;
    logic [46:0] q;
    logic [38:0] ql_p;
    logic [37:0] qh_p;
  } pipe_t;

  // floor square root, only used at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  // 2^(2^-(idx+1)) in Q30, each root taken from the previous one
  function automatic logic [30:0] exp_const(input int idx);
    logic [63:0] c;
    c = isqrt64(64'd2 << 60);
    for (int k = 0; k < idx; k++) c = isqrt64(c << 30);
    return c[30:0];
  endfunction

endpackage

/* rtl/chg_div_cell.sv */
// one restoring division step: one quotient bit per cell
// depends on chg_pkg
module chg_div_cell import chg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid_in,
  input  pipe_t       pipe_in,
  input  logic [14:0] divisor,
  output logic        valid_out,
  output pipe_t       pipe_out
);

  logic [15:0] trial;
  logic        ge;
  pipe_t       pipe_next;

  always_comb begin
    trial = {pipe_in.rem_d, pipe_in.dq[53]};
    ge = trial >= {1'b0, divisor};
    pipe_next = pipe_in;
    pipe_next.rem_d = ge ? 15'(trial - {1'b0, divisor}) : trial[14:0];
    pipe_next.dq = {pipe_in.dq[52:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else valid_out <= valid_in;
    pipe_out <= pipe_next;
  end

endmodule

/* rtl/chg_sqrt_cell.sv */
// one digit of the bitwise square root: two operand bits in, one root bit out
// depends on chg_pkg and assert_macros.svh
`include "assert_macros.svh"
module chg_sqrt_cell import chg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  input  pipe_t pipe_in,
  output logic  valid_out,
  output pipe_t pipe_out
);

  logic [30:0] rem4;
  logic [30:0] trial;
  logic        ge;
  pipe_t       pipe_next;

  always_comb begin
    rem4 = {pipe_in.rem_s, pipe_in.dq[53:52]};
    trial = {2'b00, pipe_in.root, 2'b01};
    ge = rem4 >= trial;
    pipe_next = pipe_in;
    pipe_next.rem_s = ge ? 29'(rem4 - trial) : rem4[28:0];
    pipe_next.root = {pipe_in.root[25:0], ge};
    pipe_next.dq = {pipe_in.dq[51:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else valid_out <= valid_in;
    pipe_out <= pipe_next;
  end

  // remainder never passes twice the partial root
  `CHG_ASSERT(a_rem_bound, clk, rst, valid_out |-> ({1'b0, pipe_out.rem_s} <= {2'b00, pipe_out.root, 1'b0}), "sqrt remainder out of range")

endmodule

/* rtl/chg_log_cell.sv */
// one fraction bit of log2 by squaring, for flight and reference time side by side
// depends on chg_pkg
module chg_log_cell import chg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  input  pipe_t pipe_in,
  output logic  valid_out,
  output pipe_t pipe_out
);

  logic [63:0] sq_t;
  logic [63:0] sq_r;
  logic [32:0] hi_t;
  logic [32:0] hi_r;
  pipe_t       pipe_next;

  always_comb begin
    sq_t = 64'(pipe_in.mt) * 64'(pipe_in.mt);
    sq_r = 64'(pipe_in.mr) * 64'(pipe_in.mr);
    hi_t = sq_t[63:31];
    hi_r = sq_r[63:31];
    pipe_next = pipe_in;
    pipe_next.mt = hi_t[32] ? hi_t[32:1] : hi_t[31:0];
    pipe_next.mr = hi_r[32] ? hi_r[32:1] : hi_r[31:0];
    pipe_next.ft = {pipe_in.ft[22:0], hi_t[32]};
    pipe_next.fr = {pipe_in.fr[22:0], hi_r[32]};
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else valid_out <= valid_in;
    pipe_out <= pipe_next;
  end

endmodule

/* rtl/chg_exp_cell.sv */
// one fraction bit of exp2: multiply by this cell's root of two when the bit is set
// depends on chg_pkg (exp_const)
module chg_exp_cell import chg_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  input  pipe_t pipe_in,
  output logic  valid_out,
  output pipe_t pipe_out
);

  localparam logic [30:0] ROOT_C = exp_const(IDX);

  logic [61:0] prod;
  pipe_t       pipe_next;

  always_comb begin
    prod = 62'(pipe_in.acc) * 62'(ROOT_C);
    pipe_next = pipe_in;
    pipe_next.acc = pipe_in.frac[23] ? prod[60:30] : pipe_in.acc;
    pipe_next.frac = {pipe_in.frac[22:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) valid_out <= 1'b0;
    else valid_out <= valid_in;
    pipe_out <= pipe_next;
  end

endmodule

/* rtl/particle_charge_from_tof_and_energy_loss.sv */
// top level of the charge pipeline: config registers, row of cells, final scaling
// depends on chg_pkg, chg_div_cell, chg_sqrt_cell, chg_log_cell, chg_exp_cell and assert_macros.svh
//
// Calibrated nuclear charge from time of flight and energy loss. One beat is
// taken at every clock where start is high and busy is low; busy is low at all
// times outside reset, so a new event can enter on every cycle. Each event
// comes out after the whole row of cells, with done high for one cycle; there
// is no way to hold results off, so the receiver must take every beat as it
// appears. The row holds one front stage, 54 division cells (one quotient bit
// each), 27 square root cells, one normalize stage, 24 log2 cells, three
// stages for the 1.3 power, 24 exp2 cells, one shift stage and four multiply
// stages. Configuration is written through cfg_we/cfg_index/cfg_data while no
// event is in flight; the user sees to it, the block does not enforce it.
`include "assert_macros.svh"
module particle_charge_from_tof_and_energy_loss import chg_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  hit_t                  hit,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output result_t               result
);

  localparam int LATENCY   = 1 + DIV_STEPS + SQRT_STEPS + 1 + LOG_STEPS + 3
                           + EXP_STEPS + 1 + 4;
  localparam int RES_SHIFT = 30 - OUT_FRAC_BITS;
  // floor(2^35 / 10): quotient estimate is at most one low
  localparam logic [31:0] RECIP10 = 32'd3435973836;
  localparam logic [64:0] CAP = 65'h1 << 62;
  localparam logic signed [7:0] EXP_BIAS = 8'sd14;
  localparam logic [7:0] SH_MAX = 8'd7;   // room left in p above the 31 bit product

  // configuration registers
  logic [15:0] tof_bias;
  logic [15:0] light_time;
  logic [15:0] reference_time;
  logic [12:0] de_offset;
  logic [14:0] de_divisor;
  logic [14:0] charge_base;
  logic [14:0] z_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      tof_bias       <= TOF_OFFSET_RST;
      light_time     <= LIGHT_TIME_RST;
      reference_time <= REF_TIME_RST;
      de_offset      <= DE_OFFSET_RST;
      de_divisor     <= DE_DIVISOR_RST;
      charge_base    <= Z_OFFSET_RST;
      z_slope        <= Z_SLOPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOF_OFFSET: tof_bias       <= cfg_data;
        CFG_LIGHT_TIME: light_time     <= cfg_data;
        CFG_REF_TIME:   reference_time <= cfg_data;
        CFG_DE_OFFSET:  de_offset      <= cfg_data[12:0];
        CFG_DE_DIVISOR: de_divisor     <= cfg_data[14:0];
        CFG_Z_OFFSET:   charge_base    <= cfg_data[14:0];
        CFG_Z_SLOPE:    z_slope        <= cfg_data[14:0];
        default: ;  // index past the register list is dropped
      endcase
    end
  end

  // the pipeline never stalls; only reset holds off new beats
  assign busy = rst;

  // a zero divisor behaves as one
  logic [14:0] div_eff;
  assign div_eff = (de_divisor == '0) ? 15'd1 : de_divisor;

  // ---------------------------------------------------------------------------
  // front stage: flight time, energy numerator, error checks
  // ---------------------------------------------------------------------------
  logic               front_v;
  pipe_t              front_p;
  pipe_t              front_next;
  logic [16:0]        t_sum;
  logic signed [17:0] num;

  always_comb begin
    t_sum = {1'b0, hit.tof_time} + {1'b0, tof_bias};
    num = $signed({2'b00, hit.energy_loss}) + $signed({{5{de_offset[12]}}, de_offset});
    front_next = '0;
    front_next.t = t_sum;
    // velocity check first, then the sign of the energy term
    if (t_sum <= {1'b0, light_time}) front_next.status = ST_LIGHT;
    else if (num <= 18'sd0) front_next.status = ST_ENERGY;
    else front_next.status = ST_OK;
    // numerator * 32 * 2^32, fed msb first into the division cells
    front_next.dq = {num[16:0], 37'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) front_v <= 1'b0;
    else front_v <= start && !busy;
    front_p <= front_next;
  end

  // ---------------------------------------------------------------------------
  // division cells: energy term in Q32
  // ---------------------------------------------------------------------------
  logic  dv [DIV_STEPS+1];
  pipe_t dp [DIV_STEPS+1];
  assign dv[0] = front_v;
  assign dp[0] = front_p;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    chg_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (dv[i]),
      .pipe_in   (dp[i]),
      .divisor   (div_eff),
      .valid_out (dv[i+1]),
      .pipe_out  (dp[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // square root cells: sqrt of the energy term, Q16
  // ---------------------------------------------------------------------------
  logic  sv [SQRT_STEPS+1];
  pipe_t sp [SQRT_STEPS+1];
  assign sv[0] = dv[DIV_STEPS];
  assign sp[0] = dp[DIV_STEPS];

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    chg_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (sv[i]),
      .pipe_in   (sp[i]),
      .valid_out (sv[i+1]),
      .pipe_out  (sp[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // normalize stage: leading one of flight time and reference time
  // ---------------------------------------------------------------------------
  logic  norm_v;
  pipe_t norm_p;
  pipe_t norm_next;
  logic [4:0] lead_t;
  logic [4:0] lead_r;

  always_comb begin
    lead_t = '0;
    lead_r = '0;
    for (int i = 0; i < 17; i++) if (sp[SQRT_STEPS].t[i]) lead_t = 5'(i);
    for (int i = 0; i < 16; i++) if (reference_time[i]) lead_r = 5'(i);
    norm_next = sp[SQRT_STEPS];
    norm_next.nt = lead_t;
    norm_next.nr = lead_r;
    norm_next.mt = {15'b0, sp[SQRT_STEPS].t} << (5'd31 - lead_t);
    norm_next.mr = {16'b0, reference_time} << (5'd31 - lead_r);
    norm_next.ft = '0;
    norm_next.fr = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) norm_v <= 1'b0;
    else norm_v <= sv[SQRT_STEPS];
    norm_p <= norm_next;
  end

  // ---------------------------------------------------------------------------
  // log2 cells, 24 fraction bits for both times
  // ---------------------------------------------------------------------------
  logic  lv [LOG_STEPS+1];
  pipe_t lp [LOG_STEPS+1];
  assign lv[0] = norm_v;
  assign lp[0] = norm_p;

  for (genvar i = 0; i < LOG_STEPS; i++) begin : g_log
    chg_log_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (lv[i]),
      .pipe_in   (lp[i]),
      .valid_out (lv[i+1]),
      .pipe_out  (lp[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // power 1.3: y = trunc(13 * d / 10), d = log2(ref) - log2(t)
  // ---------------------------------------------------------------------------
  logic  y1_v, y2_v, y3_v;
  pipe_t y1_p, y2_p, y3_p;
  pipe_t y1_next, y2_next, y3_next;
  logic signed [29:0] dlog;
  logic [28:0] dmag;
  logic [64:0] rprod;
  logic [33:0] resid;
  logic [29:0] qmag;
  logic [30:0] yval;

  always_comb begin
    dlog = $signed({1'b0, lp[LOG_STEPS].nr, lp[LOG_STEPS].fr})
         - $signed({1'b0, lp[LOG_STEPS].nt, lp[LOG_STEPS].ft});
    dmag = dlog[29] ? 29'(-dlog) : dlog[28:0];
    y1_next = lp[LOG_STEPS];
    y1_next.neg = dlog[29];
    // times 13 as shifts and adds
    y1_next.x13 = {dmag, 3'b0} + {1'b0, dmag, 2'b0} + {4'b0, dmag};
  end

  always_comb begin
    rprod = 65'(y1_p.x13) * 65'(RECIP10);
    y2_next = y1_p;
    y2_next.qe = rprod[64:35];
  end

  always_comb begin
    resid = {1'b0, y2_p.x13} - ({1'b0, y2_p.qe, 3'b0} + {3'b0, y2_p.qe, 1'b0});
    qmag = (resid >= 34'd10) ? 30'(y2_p.qe + 30'd1) : y2_p.qe;
    yval = y2_p.neg ? 31'(-{1'b0, qmag}) : {1'b0, qmag};
    y3_next = y2_p;
    // floor split: arithmetic top bits and the low fraction
    y3_next.ip = yval[30:24];
    y3_next.frac = yval[23:0];
    y3_next.acc = 31'h4000_0000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y1_v <= 1'b0;
      y2_v <= 1'b0;
      y3_v <= 1'b0;
    end else begin
      y1_v <= lv[LOG_STEPS];
      y2_v <= y1_v;
      y3_v <= y2_v;
    end
    y1_p <= y1_next;
    y2_p <= y2_next;
    y3_p <= y3_next;
  end

  // ---------------------------------------------------------------------------
  // exp2 cells: fraction part of 2^y in Q30
  // ---------------------------------------------------------------------------
  logic  ev [EXP_STEPS+1];
  pipe_t ep [EXP_STEPS+1];
  assign ev[0] = y3_v;
  assign ep[0] = y3_p;

  for (genvar i = 0; i < EXP_STEPS; i++) begin : g_exp
    chg_exp_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (ev[i]),
      .pipe_in   (ep[i]),
      .valid_out (ev[i+1]),
      .pipe_out  (ep[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // shift stage: apply integer exponent, Q30 to Q16
  // ---------------------------------------------------------------------------
  logic  sh_v;
  pipe_t sh_p;
  pipe_t sh_next;
  logic signed [7:0] shamt;
  logic [7:0] ramt;

  always_comb begin
    shamt = $signed({ep[EXP_STEPS].ip[6], ep[EXP_STEPS].ip}) - EXP_BIAS;
    ramt = 8'(-shamt);
    sh_next = ep[EXP_STEPS];
    if (reference_time == '0) sh_next.p = '0;   // ratio taken as zero
    else if (!shamt[7]) begin
      if (shamt > $signed(SH_MAX)) sh_next.p = '1;
      else sh_next.p = {7'b0, ep[EXP_STEPS].acc} << shamt[2:0];
    end else if (ramt >= 8'd31) sh_next.p = '0;
    else sh_next.p = {7'b0, ep[EXP_STEPS].acc >> ramt[4:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) sh_v <= 1'b0;
    else sh_v <= ev[EXP_STEPS];
    sh_p <= sh_next;
  end

  // ---------------------------------------------------------------------------
  // multiply stages: p * sqrt in two halves, then slope and offset
  // ---------------------------------------------------------------------------
  logic  m1_v, m2_v, m3_v;
  pipe_t m1_p, m2_p, m3_p;
  pipe_t m1_next, m2_next, m3_next;
  logic [64:0] ps_prod;
  logic [64:0] ps_cap;
  logic [62:0] tot;
  logic [62:0] tot_sh;
  result_t     result_next;

  always_comb begin
    m1_next = sh_p;
    m1_next.pp_lo = 46'(sh_p.p[18:0]) * 46'(sh_p.root);
    m1_next.pp_hi = 46'(sh_p.p[37:19]) * 46'(sh_p.root);
  end

  always_comb begin
    ps_prod = {m1_p.pp_hi, 19'b0} + 65'(m1_p.pp_lo);
    ps_cap = (ps_prod > CAP) ? CAP : ps_prod;
    m2_next = m1_p;
    m2_next.q = ps_cap[62:16];
  end

  always_comb begin
    m3_next = m2_p;
    m3_next.ql_p = 39'(m2_p.q[23:0]) * 39'(z_slope);
    m3_next.qh_p = 38'(m2_p.q[46:24]) * 38'(z_slope);
  end

  always_comb begin
    tot = {1'b0, m3_p.qh_p, 24'b0} + 63'(m3_p.ql_p) + 63'({charge_base, 16'b0});
    tot_sh = tot >> RES_SHIFT;
    result_next.status = m3_p.status;
    if (m3_p.status != ST_OK) result_next.charge_value = '0;
    else if (|tot_sh[62:16]) result_next.charge_value = 16'hFFFF;
    else result_next.charge_value = tot_sh[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
      m2_v <= 1'b0;
      m3_v <= 1'b0;
      done <= 1'b0;
    end else begin
      m1_v <= sh_v;
      m2_v <= m1_v;
      m3_v <= m2_v;
      done <= m3_v;
    end
    m1_p <= m1_next;
    m2_p <= m2_next;
    m3_p <= m3_next;
    result <= result_next;
  end

  // every accepted beat comes out with done once it has passed the whole row
  `CHG_ASSERT(a_latency, clk, rst, start && !busy |-> ##LATENCY done, "late result")
  // an error result carries no charge
  `CHG_ASSERT(a_err_zero, clk, rst, done && (result.status != ST_OK) |-> (result.charge_value == '0), "charge on error")
  // reset flushes the row
  `CHG_ASSERT_NORST(a_rst_flush, clk, rst |=> !done, "result after reset")

endmodule
